// ===== design/lcdltg_pkg.sv =====
// lcdltg_pkg: timing constants, phase encoding and result layout for the
// lcd line timing generator; no dependencies
package lcdltg_pkg;

   // field widths
   localparam int ELAPSED_W = 12;
   localparam int CNT_W     = 17;
   localparam int LINE_W    = 8;
   localparam int MATCH_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;

   // scanline timing
   localparam int DRAW_CLOCKS     = 960;
   localparam int HBLANK_CLOCKS   = 272;
   localparam int VISIBLE_LINES   = 160;
   localparam int TOTAL_LINES     = 228;
   localparam int HBLANK_FLAG_LAG = 46;

   localparam logic signed [CNT_W-1:0] DRAW_LEN     = CNT_W'(DRAW_CLOCKS);
   localparam logic signed [CNT_W-1:0] HBLANK_LEN   = CNT_W'(HBLANK_CLOCKS);
   localparam logic signed [CNT_W-1:0] HBLANK_LEVEL =
      CNT_W'(HBLANK_CLOCKS - HBLANK_FLAG_LAG);
   // low bound of the countdown, one bit wider than the countdown itself
   localparam logic signed [CNT_W:0]   CNT_MIN      = -(18'sd1 <<< (CNT_W - 1));

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_LINE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VBLANK_IEN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HBLANK_IEN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_IEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCED_BLANK = 3'd4;

   typedef enum logic [3:0] {
      PH_DRAW    = 4'b0001,
      PH_HBLANK  = 4'b0010,
      PH_VDRAW   = 4'b0100,
      PH_VHBLANK = 4'b1000
   } phase_type;

   // result item, first field in the highest bits
   typedef struct packed {
      logic                    phase_changed;
      logic                    irq_line_match;
      logic                    irq_hblank;
      logic                    irq_vblank;
      logic                    line_match;
      logic                    in_hblank;
      logic                    in_vblank;
      logic                    draw_blank_line;
      logic                    draw_request;
      logic [LINE_W-1:0]       current_line;
      logic signed [CNT_W-1:0] clocks_remaining;
   } rsp_type;

   localparam int RSP_W     = $bits(rsp_type);
   localparam int RSP_BYTES = (RSP_W + 7) / 8;
   localparam int REQ_BYTES = (ELAPSED_W + 7) / 8;

endpackage

// ===== design/lcd_line_timing_generator.sv =====
// lcd_line_timing_generator: top level, scanline phase machine and status
// flags with stream input and output registers; uses lcdltg_pkg

// Takes one transfer per clock on req_ and gives one result transfer per item
// on rsp_ when rsp_tready stays high. Each item passes an input register, then
// the update logic (saturating subtract, expiry compare, phase step and line
// advance) that also writes the countdown, phase, line counter and flags, then
// the result register. The state loop runs from the state registers through
// the update logic straight back to them, so items may follow back to back and
// the block sustains one item per clock; a stalled rsp_ side holds the result
// register and backs the input register up after one more item.
// Configuration is written through csr_we/csr_index/csr_wdata; writes to
// indexes beyond forced_blank are dropped. Reset is synchronous, active high.
module lcd_line_timing_generator
   import lcdltg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request stream: [11:0] elapsed_clocks
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_BYTES*8-1:0]   req_tdata,
   // result stream: [16:0] clocks_remaining, [24:17] current_line,
   // [25] draw_request, [26] draw_blank_line, [27] in_vblank, [28] in_hblank,
   // [29] line_match, [30] irq_vblank, [31] irq_hblank, [32] irq_line_match,
   // [33] phase_changed
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_BYTES*8-1:0]   rsp_tdata,
   // register writes
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_wdata
);

   // configuration registers
   logic [MATCH_W-1:0] match_line_ff;
   logic               vblank_ien_ff;
   logic               hblank_ien_ff;
   logic               match_ien_ff;
   logic               forced_blank_ff;

   // input stage
   logic                 in_valid_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;

   // result stage
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // timing state
   phase_type               phase_ff,   phase_in;
   logic signed [CNT_W-1:0] cnt_ff,     cnt_in;
   logic [LINE_W-1:0]       line_ff,    line_in;
   logic                    hdone_ff,   hdone_in;
   logic                    vblank_ff,  vblank_in;
   logic                    hblank_ff,  hblank_in;
   logic                    match_ff,   match_in;

   // update datapath
   logic signed [CNT_W:0]   cnt_diff;
   logic signed [CNT_W-1:0] cnt_sat;
   logic                    expired;
   logic [LINE_W:0]         line_next;
   logic                    line_adv;
   logic                    draw_req;
   logic                    irq_v;
   logic                    irq_h;
   logic                    irq_m;
   logic                    changed;

   logic out_free;
   logic step;

   // the result register frees when empty or when its transfer completes
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_BYTES*8-RSP_W){1'b0}}, rsp_ff};

   // ---------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         match_line_ff   <= '0;
         vblank_ien_ff   <= 1'b0;
         hblank_ien_ff   <= 1'b0;
         match_ien_ff    <= 1'b0;
         forced_blank_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MATCH_LINE:   match_line_ff   <= csr_wdata[MATCH_W-1:0];
            CSR_VBLANK_IEN:   vblank_ien_ff   <= csr_wdata[0];
            CSR_HBLANK_IEN:   hblank_ien_ff   <= csr_wdata[0];
            CSR_MATCH_IEN:    match_ien_ff    <= csr_wdata[0];
            CSR_FORCED_BLANK: forced_blank_ff <= csr_wdata[0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // countdown: subtract elapsed clocks, clamp at the low bound
   // ---------------------------------------------------------------------
   always_comb begin
      cnt_diff = $signed({cnt_ff[CNT_W-1], cnt_ff})
               - $signed({{(CNT_W+1-ELAPSED_W){1'b0}}, elapsed_ff});
      if (cnt_diff < CNT_MIN) begin
         cnt_sat = CNT_MIN[CNT_W-1:0];
      end else begin
         cnt_sat = cnt_diff[CNT_W-1:0];
      end
      // phase ends once the countdown reaches zero or goes below
      expired   = cnt_sat[CNT_W-1] || (cnt_sat == '0);
      line_next = {1'b0, line_ff} + (LINE_W+1)'(1);
   end

   // ---------------------------------------------------------------------
   // phase machine, at most one phase change per item
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_sat;
      line_in   = line_ff;
      hdone_in  = hdone_ff;
      vblank_in = vblank_ff;
      hblank_in = hblank_ff;
      match_in  = match_ff;
      line_adv  = 1'b0;
      draw_req  = 1'b0;
      irq_v     = 1'b0;
      irq_h     = 1'b0;
      irq_m     = 1'b0;
      changed   = 1'b0;

      unique case (phase_ff) inside
         PH_DRAW, PH_VDRAW: begin
            if (expired) begin
               // visible draw end asks for the line to be drawn
               if (phase_ff == PH_DRAW) begin
                  draw_req = 1'b1;
                  changed  = 1'b1;
                  phase_in = PH_HBLANK;
               end else begin
                  phase_in = PH_VHBLANK;
               end
               irq_h    = hblank_ien_ff;
               cnt_in   = cnt_sat + HBLANK_LEN;
               hdone_in = 1'b0;
            end
         end
         PH_HBLANK, PH_VHBLANK: begin
            if (expired) begin
               // line start: advance counter, hblank flag drops
               line_adv  = 1'b1;
               hblank_in = 1'b0;
               cnt_in    = cnt_sat + DRAW_LEN;
               if (phase_ff == PH_HBLANK) begin
                  changed = 1'b1;
                  if (line_next == (LINE_W+1)'(VISIBLE_LINES)) begin
                     vblank_in = 1'b1;
                     irq_v     = vblank_ien_ff;
                     phase_in  = PH_VDRAW;
                     line_in   = line_next[LINE_W-1:0];
                  end else if (line_next >= (LINE_W+1)'(TOTAL_LINES)) begin
                     // counter runs past total outside vblank: wrap, keep drawing
                     phase_in = PH_DRAW;
                     line_in  = '0;
                  end else begin
                     phase_in = PH_DRAW;
                     line_in  = line_next[LINE_W-1:0];
                  end
               end else begin
                  if (line_next >= (LINE_W+1)'(TOTAL_LINES)) begin
                     // end of frame
                     phase_in = PH_DRAW;
                     line_in  = '0;
                  end else begin
                     // vblank flag drops on the last line of the frame
                     if (line_next == (LINE_W+1)'(TOTAL_LINES - 1)) begin
                        vblank_in = 1'b0;
                     end
                     phase_in = PH_VDRAW;
                     line_in  = line_next[LINE_W-1:0];
                  end
               end
            end else if ((cnt_sat <= HBLANK_LEVEL) && !hdone_ff) begin
               // hblank flag rises late, once per line
               hblank_in = 1'b1;
               hdone_in  = 1'b1;
            end
         end
         default: begin
            phase_in = PH_DRAW;
         end
      endcase

      // line compare only after a line advance
      if (line_adv) begin
         match_in = (line_in == match_line_ff);
         irq_m    = match_in && match_ien_ff;
      end
   end

   always_comb begin
      rsp_in.clocks_remaining = cnt_in;
      rsp_in.current_line     = line_in;
      rsp_in.draw_request     = draw_req;
      rsp_in.draw_blank_line  = draw_req && forced_blank_ff;
      rsp_in.in_vblank        = vblank_in;
      rsp_in.in_hblank        = hblank_in;
      rsp_in.line_match       = match_in;
      rsp_in.irq_vblank       = irq_v;
      rsp_in.irq_hblank       = irq_h;
      rsp_in.irq_line_match   = irq_m;
      rsp_in.phase_changed    = changed;
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_DRAW;
         cnt_ff       <= DRAW_LEN;
         line_ff      <= '0;
         hdone_ff     <= 1'b0;
         vblank_ff    <= 1'b0;
         hblank_ff    <= 1'b0;
         match_ff     <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (step) begin
            phase_ff  <= phase_in;
            cnt_ff    <= cnt_in;
            line_ff   <= line_in;
            hdone_ff  <= hdone_in;
            vblank_ff <= vblank_in;
            hblank_ff <= hblank_in;
            match_ff  <= match_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         elapsed_ff <= req_tdata[ELAPSED_W-1:0];
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
`ifndef ASSERT_OFF
   // line counter never leaves the frame
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      line_ff < LINE_W'(TOTAL_LINES))
      else $error("line counter beyond frame");

   // a draw request only comes with the end of a visible draw phase
   a_draw_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.draw_request |-> rsp_ff.phase_changed && !rsp_ff.irq_vblank)
      else $error("draw request without visible draw end");

   // vblank interrupt only with the vblank flag set and the line at the visible end
   a_vblank_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.irq_vblank |->
         rsp_ff.in_vblank && (rsp_ff.current_line == LINE_W'(VISIBLE_LINES)))
      else $error("vblank interrupt out of place");

   // a stalled result keeps the timing state frozen
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(line_ff) && $stable(cnt_ff))
      else $error("state moved while result stalled");
`endif

endmodule

// ===== verif/lcd_line_timing_generator_tb.sv =====
// lcd_line_timing_generator_tb: self-checking testbench for the lcd line timing generator
// holds a scanline timing predictor, a directed table and random runs
// depends on lcdltg_pkg and the lcd_line_timing_generator design only
module lcd_line_timing_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lcdltg_pkg::*;

   // register indexes past forced_blank, the design must drop these writes
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   // countdown low bound as a plain integer
   localparam int COUNT_FLOOR = -(1 << (CNT_W - 1));

   // receiver hold-off length for the back-pressure run
   localparam int LONG_HOLD_CYCLES = 300;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_BYTES*8-1:0] req_tdata  = '0;

   // result side
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_BYTES*8-1:0] rsp_tdata;

   // register write port
   logic                   csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DAT_W-1:0]   csr_wdata = '0;

   lcd_line_timing_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // scanline timing predictor: own copy of the registers and the state
   // ---------------------------------------------------------------------
   logic [MATCH_W-1:0] cfg_match_line;
   bit                 cfg_vblank_ien;
   bit                 cfg_hblank_ien;
   bit                 cfg_match_ien;
   bit                 cfg_forced_blank;

   phase_type          scan_phase;
   int                 countdown;
   logic [LINE_W-1:0]  line_cnt;
   bit                 lag_done;
   bit                 vblank_st;
   bit                 hblank_st;
   bit                 match_st;

   // line results expected from the design, oldest first
   rsp_type            line_results_q[$];
   int                 failures = 0;

   // idle and stall odds in percent, set per run phase
   int                 req_idle_pct  = 0;
   int                 rsp_stall_pct = 0;

   // long hold-off requests from the stimulus, served by the receiver
   int                 hold_requests = 0;
   int                 hold_served   = 0;
   int                 hold_left     = 0;

   task automatic reset_scanline_model();
      cfg_match_line   = '0;
      cfg_vblank_ien   = 1'b0;
      cfg_hblank_ien   = 1'b0;
      cfg_match_ien    = 1'b0;
      cfg_forced_blank = 1'b0;
      scan_phase       = PH_DRAW;
      countdown        = DRAW_CLOCKS;
      line_cnt         = '0;
      lag_done         = 1'b0;
      vblank_st        = 1'b0;
      hblank_st        = 1'b0;
      match_st         = 1'b0;
   endtask

   // values are masked to the register width, unknown indexes dropped
   function automatic void apply_reg_write(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DAT_W-1:0] val);
      case (idx)
         CSR_MATCH_LINE:   cfg_match_line   = val[MATCH_W-1:0];
         CSR_VBLANK_IEN:   cfg_vblank_ien   = val[0];
         CSR_HBLANK_IEN:   cfg_hblank_ien   = val[0];
         CSR_MATCH_IEN:    cfg_match_ien    = val[0];
         CSR_FORCED_BLANK: cfg_forced_blank = val[0];
         default: ;
      endcase
   endfunction

   // advance the scanline machine by one item, at most one phase change
   function automatic rsp_type step_scanline(logic [ELAPSED_W-1:0] elapsed);
      rsp_type r;
      int      next_line;
      r = '0;
      countdown = countdown - int'(elapsed);
      // countdown saturates at its low bound
      if (countdown < COUNT_FLOOR) countdown = COUNT_FLOOR;

      case (scan_phase)
         PH_DRAW, PH_VDRAW: begin
            if (countdown <= 0) begin
               // end of a draw period, only the visible one asks for a draw
               if (scan_phase == PH_DRAW) begin
                  r.draw_request  = 1'b1;
                  r.phase_changed = 1'b1;
                  scan_phase      = PH_HBLANK;
               end else begin
                  scan_phase      = PH_VHBLANK;
               end
               r.irq_hblank = cfg_hblank_ien;
               countdown    = countdown + HBLANK_CLOCKS;
               lag_done     = 1'b0;
            end
         end
         default: begin
            if (countdown <= 0) begin
               // end of hblank: next line, hblank flag cleared at line start
               next_line = int'(line_cnt) + 1;
               hblank_st = 1'b0;
               countdown = countdown + DRAW_CLOCKS;
               if (scan_phase == PH_HBLANK) begin
                  r.phase_changed = 1'b1;
                  if (next_line == VISIBLE_LINES) begin
                     vblank_st    = 1'b1;
                     r.irq_vblank = cfg_vblank_ien;
                     scan_phase   = PH_VDRAW;
                  end else begin
                     // line beyond total in the visible area wraps as well
                     if (next_line >= TOTAL_LINES) next_line = 0;
                     scan_phase = PH_DRAW;
                  end
               end else begin
                  if (next_line >= TOTAL_LINES) begin
                     next_line  = 0;
                     scan_phase = PH_DRAW;
                  end else begin
                     if (next_line == TOTAL_LINES - 1) vblank_st = 1'b0;
                     scan_phase = PH_VDRAW;
                  end
               end
               line_cnt         = LINE_W'(next_line);
               match_st         = (line_cnt == cfg_match_line);
               r.irq_line_match = match_st & cfg_match_ien;
            end else if (countdown <= HBLANK_CLOCKS - HBLANK_FLAG_LAG && !lag_done) begin
               // hblank flag rises some clocks into hblank, once per line
               hblank_st = 1'b1;
               lag_done  = 1'b1;
            end
         end
      endcase

      r.clocks_remaining = CNT_W'(countdown);
      r.current_line     = line_cnt;
      r.draw_blank_line  = r.draw_request & cfg_forced_blank;
      r.in_vblank        = vblank_st;
      r.in_hblank        = hblank_st;
      r.line_match       = match_st;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   task automatic check_line_result(rsp_type got);
      rsp_type want;
      if (line_results_q.size() == 0) begin
         $error("result transfer with nothing expected: clocks_remaining %0d, line %0d",
                got.clocks_remaining, got.current_line);
         failures++;
         return;
      end
      want = line_results_q.pop_front();
      check_field("clocks_remaining", want.clocks_remaining, got.clocks_remaining);
      check_field("current_line", want.current_line, got.current_line);
      check_field("draw_request", want.draw_request, got.draw_request);
      check_field("draw_blank_line", want.draw_blank_line, got.draw_blank_line);
      check_field("in_vblank", want.in_vblank, got.in_vblank);
      check_field("in_hblank", want.in_hblank, got.in_hblank);
      check_field("line_match", want.line_match, got.line_match);
      check_field("irq_vblank", want.irq_vblank, got.irq_vblank);
      check_field("irq_hblank", want.irq_hblank, got.irq_hblank);
      check_field("irq_line_match", want.irq_line_match, got.irq_line_match);
      check_field("phase_changed", want.phase_changed, got.phase_changed);
   endtask

   // receiver: checks each result transfer, then picks next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_line_result(rsp_type'(rsp_tdata[RSP_W-1:0]));
      // a new hold-off request loads the counter
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // request driving and register writes
   // ---------------------------------------------------------------------
   // offer one item, wait for its transfer, then predict its result;
   // valid is left high so a following item goes out back to back
   task automatic send_item(input logic [ELAPSED_W-1:0] elapsed,
                            input bit typed = 1'b0, input rsp_type want = '0);
      rsp_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_BYTES*8-ELAPSED_W){1'b0}}, elapsed};
      do @(posedge clock); while (!req_tready);
      predicted = step_scanline(elapsed);
      line_results_q.push_back(typed ? want : predicted);
   endtask

   // stop offering and wait until every expected result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (line_results_q.size() != 0) @(posedge clock);
      // pipeline is two deep, let it settle before touching registers
      repeat (3) @(posedge clock);
   endtask

   // write enable stays high for a burst of writes, caller lowers it
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_reg_write(idx, val);
   endtask

   task automatic program_regs(logic [CSR_DAT_W-1:0] match_line, logic [CSR_DAT_W-1:0] ven,
                               logic [CSR_DAT_W-1:0] hen, logic [CSR_DAT_W-1:0] men,
                               logic [CSR_DAT_W-1:0] blank);
      wait_drained();
      write_reg(CSR_MATCH_LINE, match_line);
      write_reg(CSR_VBLANK_IEN, ven);
      write_reg(CSR_HBLANK_IEN, hen);
      write_reg(CSR_MATCH_IEN, men);
      write_reg(CSR_FORCED_BLANK, blank);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // directed table: item rows and register write rows
   // ---------------------------------------------------------------------
   typedef struct {
      bit                   is_write;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [CSR_DAT_W-1:0] reg_value;
      logic [ELAPSED_W-1:0] elapsed;
      bit                   typed;
      rsp_type              want;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic void add_step(logic [ELAPSED_W-1:0] elapsed);
      directed_row_type row;
      row = '{default: '0};
      row.elapsed = elapsed;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed_step(logic [ELAPSED_W-1:0] elapsed, rsp_type want);
      directed_row_type row;
      row = '{default: '0};
      row.elapsed = elapsed;
      row.typed   = 1'b1;
      row.want    = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      directed_row_type row;
      row = '{default: '0};
      row.is_write  = 1'b1;
      row.reg_index = idx;
      row.reg_value = val;
      directed_rows.push_back(row);
   endfunction

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      rsp_type              w;
      bit                   csr_open;
      int                   pick;
      int                   run_len;
      int                   sent;
      logic [ELAPSED_W-1:0] e;
      int                   idle_send[4];
      int                   idle_recv[4];

      reset_scanline_model();

      // right after reset: zero clocks leave the countdown at a full draw period
      w = '0;
      w.clocks_remaining = CNT_W'(DRAW_CLOCKS);
      add_typed_step(12'd0, w);
      // exactly a draw period: draw ends, visible draw asks for the line
      w = '0;
      w.clocks_remaining = CNT_W'(HBLANK_CLOCKS);
      w.draw_request     = 1'b1;
      w.phase_changed    = 1'b1;
      add_typed_step(12'd960, w);
      // largest step in hblank: next line with the overshoot carried
      w = '0;
      w.clocks_remaining = CNT_W'(960 - (4095 - 272));
      w.current_line     = 8'd1;
      w.phase_changed    = 1'b1;
      add_typed_step(12'hfff, w);
      // every interrupt and forced blank on, match on line 3
      add_write(CSR_MATCH_LINE, 8'd3);
      add_write(CSR_VBLANK_IEN, 8'd1);
      add_write(CSR_HBLANK_IEN, 8'd1);
      add_write(CSR_MATCH_IEN, 8'd1);
      add_write(CSR_FORCED_BLANK, 8'd1);
      // negative overshoot worked off one phase change per item
      repeat (6) add_step(12'd0);
      // countdown hits zero exactly, then the hblank flag lag edge
      add_step(12'd833);
      add_step(12'd45);
      add_step(12'd1);
      add_step(12'd1);
      add_step(12'd225);
      // unknown indexes are dropped, wide values masked to one bit
      add_write(CSR_UNUSED_LO, 8'hff);
      add_write(CSR_UNUSED_HI, 8'h00);
      add_write(CSR_FORCED_BLANK, 8'hfe);
      add_write(CSR_MATCH_LINE, 8'hff);
      add_step(12'hfff);
      add_step(12'hfff);
      add_step(12'h800);
      add_step(12'h555);
      add_step(12'haaa);
      add_step(12'd1);

      // synchronous reset
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the table, a write burst starts once the pipeline is empty
      csr_open = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            if (!csr_open) wait_drained();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            csr_open = 1'b1;
         end else begin
            if (csr_open) begin
               csr_we   <= 1'b0;
               csr_open = 1'b0;
            end
            send_item(directed_rows[i].elapsed, directed_rows[i].typed,
                      directed_rows[i].want);
         end
      end

      // idle mixes: none, sender mostly idle, receiver mostly stalled, light both
      idle_send = '{0, 79, 0, 6};
      idle_recv = '{0, 0, 79, 6};

      for (int ph = 0; ph < 8; ph++) begin
         // new settings between phases, extremes first; the sender pauses here
         // until every result is back
         if (ph == 0)
            program_regs(8'd0, 8'd1, 8'd1, 8'd1, 8'd1);
         else if (ph == 1)
            program_regs(8'hff, 8'd0, 8'd0, 8'd0, 8'd0);
         else if (ph == 2)
            program_regs(8'd159, 8'd1, 8'd0, 8'd1, 8'd0);
         else
            program_regs(8'($urandom_range(255)), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
         req_idle_pct  = idle_send[ph % 4];
         rsp_stall_pct = idle_recv[ph % 4];
         // long receiver hold-off while items keep coming: input backs up
         if (ph % 4 == 0) hold_requests++;

         sent = 0;
         while (sent < 60) begin
            pick = $urandom_range(99);
            // flood runs are long enough to drive the countdown to its floor
            run_len = (pick < 10) ? 24 : $urandom_range(16, 8);
            for (int k = 0; k < run_len; k++) begin
               if (pick < 10)
                  e = '1;
               else if (pick < 35)
                  e = '0;                              // works off overshoot fast
               else if (pick < 65)
                  e = ELAPSED_W'($urandom_range(1300, 500));
               else if (pick < 85)
                  e = ELAPSED_W'($urandom_range(400));
               else
                  e = ELAPSED_W'($urandom);
               send_item(e);
            end
            sent += run_len;
         end
      end

      // everything back, then a few more cycles for stray results
      wait_drained();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #(2_000_000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
